>>> hw/rtl/cpm_pkg.sv
// Shared types and constants for the command prefix matcher.
// Used by the entry state memory, the core and the port checker.
package cpm_pkg;

  localparam int unsigned NUM_ENTRIES_DEF = 16;
  localparam int unsigned NAME_LEN_DEF    = 16;
  localparam int unsigned MAX_RESULTS     = 16;

  // Fixed field widths of the stream and register interface.
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned IDX_W       = 4;
  localparam int unsigned STR_W       = 4;
  localparam int unsigned TIE_W       = 5;
  localparam int unsigned CNT_REG_W   = 5;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  // Word index of the entry count register (paddr bit 2).
  localparam logic REG_ENTRY_COUNT = 1'b0;

  typedef enum logic [1:0] {
    KIND_EXACT   = 2'd0,
    KIND_SUGGEST = 2'd1,
    KIND_EMPTY   = 2'd2
  } kind_e;

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  // Control group from the core to the entry state memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_still;
    logic clear;
  } st_ctrl_t;

endpackage

>>> hw/rtl/cpm_state_mem.sv
// Per-entry match state (still-matching flag and match length) in a synchronous memory.
// Depends on cpm_pkg for the control struct and default sizes.
module cpm_state_mem
  import cpm_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int unsigned NAME_LEN    = NAME_LEN_DEF,
  localparam int unsigned EW  = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1,
  localparam int unsigned MLW = $clog2(NAME_LEN)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  st_ctrl_t       ctrl_i,
  input  logic [EW-1:0]  rd_addr_i,
  input  logic [EW-1:0]  wr_addr_i,
  input  logic [MLW-1:0] wr_len_i,
  output logic           rd_still_o,
  output logic [MLW-1:0] rd_len_o
);

  logic           still_mem [NUM_ENTRIES];
  logic [MLW-1:0] len_mem   [NUM_ENTRIES];

  // An entry not written since the last clear reads as its reset value.
  logic [NUM_ENTRIES-1:0] written_q;
  logic                   rd_written_q;
  logic                   rd_still_q;
  logic [MLW-1:0]         rd_len_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      still_mem[wr_addr_i] <= ctrl_i.wr_still;
      len_mem[wr_addr_i]   <= wr_len_i;
    end
    if (ctrl_i.rd_en) begin
      rd_still_q <= still_mem[rd_addr_i];
      rd_len_q   <= len_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (ctrl_i.clear) begin
        written_q <= '0;
      end else if (ctrl_i.wr_en) begin
        written_q[wr_addr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_written_q <= written_q[rd_addr_i];
      end
    end
  end

  assign rd_still_o = rd_written_q ? rd_still_q : 1'b1;
  assign rd_len_o   = rd_written_q ? rd_len_q : '0;

endmodule

>>> hw/rtl/command_prefix_matcher_core.sv
// Command prefix matcher core: name table memory, query walk and result listing.
// Depends on cpm_pkg and cpm_state_mem.
// A name character item is written while the core stays idle and ready for the next item;
// a query character walks every entry, one read-modify-write of the entry state memory per entry.
// A terminator scans the n configured entries and probes the first best one, then shows an exact or
// empty-table result (an empty table skips the scan); suggestions read and evaluate each entry visited.
module command_prefix_matcher_core
  import cpm_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = NUM_ENTRIES_DEF,
  parameter int unsigned NAME_LEN    = NAME_LEN_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Configuration port
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [PADDR_W-1:0]     paddr,
  input  logic [PDATA_W-1:0]     pwdata,
  output logic [PDATA_W-1:0]     prdata,
  output logic                   pready,
  // Input items
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,  // entry[3:0], position[7:4], char_code[15:8]
  input  logic [0:0]             s_tuser,  // mode[0]
  // Result items
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,  // entry_index[3:0], strength[7:4], tie_count[12:8]
  output logic [1:0]             m_tuser,  // kind[1:0]
  output logic                   m_tlast
);

  localparam int unsigned EW    = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int unsigned CW    = $clog2(NUM_ENTRIES + 1);
  localparam int unsigned MLW   = $clog2(NAME_LEN);
  localparam int unsigned DEPTH = NUM_ENTRIES * NAME_LEN;
  localparam int unsigned AW    = $clog2(DEPTH);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_WALK    = 7'b0000010,
    ST_SCAN    = 7'b0000100,
    ST_PROBE   = 7'b0001000,
    ST_DECIDE  = 7'b0010000,
    ST_LIST_RD = 7'b0100000,
    ST_LIST_EV = 7'b1000000
  } state_e;

  // Input fields
  mode_e              in_mode;
  logic [IDX_W-1:0]   in_entry;
  logic [3:0]         in_pos;
  logic [CHAR_W-1:0]  in_char;
  logic               in_fire;

  assign in_mode  = mode_e'(s_tuser[0]);
  assign in_entry = s_tdata[3:0];
  assign in_pos   = s_tdata[7:4];
  assign in_char  = s_tdata[15:8];

  // Control and working registers
  state_e             state_q, state_d;
  logic [CW-1:0]      cnt_q, cnt_d;
  logic               pv_q, pv_d;
  logic [4:0]         qpos_q, qpos_d;
  logic [CNT_REG_W-1:0] entry_count_q;
  logic [EW-1:0]      pidx_q, pidx_d;
  logic [CHAR_W-1:0]  char_q, char_d;
  logic [MLW-1:0]     best_q, best_d;
  logic [EW-1:0]      first_q, first_d;
  logic [CW-1:0]      ties_q, ties_d;
  logic               first_still_q, first_still_d;
  logic [CW-1:0]      listed_q, listed_d;
  logic               empty_q, empty_d;

  // Output register
  logic               m_tvalid_q;
  kind_e              out_kind_q, out_kind_d;
  logic [IDX_W-1:0]   out_idx_q, out_idx_d;
  logic [STR_W-1:0]   out_str_q, out_str_d;
  logic [TIE_W-1:0]   out_ties_q, out_ties_d;
  logic               out_last_q, out_last_d;
  logic               out_load;
  logic               out_free;

  // Name table
  logic [CHAR_W-1:0]  name_mem [DEPTH];
  logic               tbl_we;
  logic [AW-1:0]      tbl_wr_addr;
  logic               tbl_rd_en;
  logic [EW-1:0]      tbl_rd_idx;
  logic [AW-1:0]      tbl_rd_addr;
  logic [CHAR_W-1:0]  tbl_char_q;
  logic [CHAR_W-1:0]  name_ch;
  logic               q_in_range;
  logic [4:0]         rd_pos;
  logic               load_ok;

  // Entry state memory
  st_ctrl_t           st_ctrl;
  logic [EW-1:0]      st_rd_addr;
  logic [MLW-1:0]     st_wr_len;
  logic               st_rd_still;
  logic [MLW-1:0]     st_rd_len;

  logic [CW-1:0]      n_ents;
  logic [CW-1:0]      total;
  logic               walk_issue;
  logic               scan_issue;
  logic               hit;
  logic               exact_hit;
  logic               cfg_we;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_ENTRY_COUNT);
  assign prdata = (paddr[2] == REG_ENTRY_COUNT) ? PDATA_W'(entry_count_q) : '0;

  assign n_ents = (32'(entry_count_q) < NUM_ENTRIES) ? CW'(entry_count_q) : CW'(NUM_ENTRIES);
  assign total  = (32'(ties_q) < MAX_RESULTS) ? ties_q : CW'(MAX_RESULTS);

  // The last slot of every name and anything past it reads as a terminator.
  assign q_in_range  = (32'(qpos_q) + 32'd1) < NAME_LEN;
  assign rd_pos      = q_in_range ? qpos_q : 5'd0;
  assign name_ch     = q_in_range ? tbl_char_q : '0;
  assign load_ok     = (32'(in_entry) < NUM_ENTRIES) && (32'(in_pos) < NAME_LEN);
  assign tbl_wr_addr = AW'(32'(in_entry) * NAME_LEN + 32'(in_pos));
  assign tbl_rd_addr = AW'(32'(tbl_rd_idx) * NAME_LEN + 32'(rd_pos));

  assign s_tready   = (state_q == ST_IDLE);
  assign in_fire    = s_tvalid && s_tready;
  assign out_free   = !m_tvalid_q || m_tready;
  assign walk_issue = 32'(cnt_q) < NUM_ENTRIES;
  assign scan_issue = cnt_q < n_ents;
  assign hit        = st_rd_still && (name_ch == char_q);
  assign exact_hit  = (ties_q == CW'(1)) && first_still_q && (name_ch == '0);

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    pv_d          = 1'b0;
    qpos_d        = qpos_q;
    pidx_d        = cnt_q[EW-1:0];
    char_d        = char_q;
    best_d        = best_q;
    first_d       = first_q;
    ties_d        = ties_q;
    first_still_d = first_still_q;
    listed_d      = listed_q;
    empty_d       = empty_q;
    st_ctrl       = '0;
    st_rd_addr    = cnt_q[EW-1:0];
    st_wr_len     = st_rd_len;
    tbl_we        = 1'b0;
    tbl_rd_en     = 1'b0;
    tbl_rd_idx    = cnt_q[EW-1:0];
    out_load      = 1'b0;
    out_kind_d    = KIND_SUGGEST;
    out_idx_d     = IDX_W'(cnt_q[EW-1:0]);
    out_str_d     = STR_W'(best_q);
    out_ties_d    = TIE_W'(ties_q);
    out_last_d    = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_mode == MODE_LOAD) begin
            tbl_we = load_ok;
          end else if (in_char != '0) begin
            char_d  = in_char;
            cnt_d   = '0;
            state_d = ST_WALK;
          end else begin
            cnt_d         = '0;
            best_d        = '0;
            first_d       = '0;
            ties_d        = '0;
            first_still_d = 1'b1;
            empty_d       = (n_ents == '0);
            state_d       = (n_ents == '0) ? ST_DECIDE : ST_SCAN;
          end
        end
      end

      // One entry read per cycle; the entry read in the previous cycle is written back.
      ST_WALK: begin
        if (walk_issue) begin
          st_ctrl.rd_en = 1'b1;
          tbl_rd_en     = 1'b1;
          cnt_d         = cnt_q + 1'b1;
        end
        pv_d = walk_issue;
        if (pv_q) begin
          st_ctrl.wr_en    = 1'b1;
          st_ctrl.wr_still = hit;
          st_wr_len        = hit ? MLW'(st_rd_len + 1'b1) : st_rd_len;
          if (!walk_issue) begin
            qpos_d  = (qpos_q == 5'd31) ? qpos_q : qpos_q + 5'd1;
            state_d = ST_IDLE;
          end
        end
      end

      ST_SCAN: begin
        if (scan_issue) begin
          st_ctrl.rd_en = 1'b1;
          cnt_d         = cnt_q + 1'b1;
        end
        pv_d = scan_issue;
        if (pv_q) begin
          if (st_rd_len > best_q) begin
            best_d        = st_rd_len;
            first_d       = pidx_q;
            ties_d        = CW'(1);
            first_still_d = st_rd_still;
          end else if (st_rd_len == best_q) begin
            ties_d = ties_q + 1'b1;
            // With nothing stronger, entry 0 is the first of the tie.
            if (pidx_q == '0) begin
              first_still_d = st_rd_still;
            end
          end
          if (!scan_issue) begin
            state_d = ST_PROBE;
          end
        end
      end

      ST_PROBE: begin
        tbl_rd_en  = 1'b1;
        tbl_rd_idx = first_q;
        state_d    = ST_DECIDE;
      end

      ST_DECIDE: begin
        if (empty_q || exact_hit) begin
          if (out_free) begin
            out_load = 1'b1;
            out_last_d = 1'b1;
            if (empty_q) begin
              out_kind_d = KIND_EMPTY;
              out_idx_d  = '0;
              out_str_d  = '0;
              out_ties_d = '0;
            end else begin
              out_kind_d = KIND_EXACT;
              out_idx_d  = IDX_W'(first_q);
            end
            st_ctrl.clear = 1'b1;
            qpos_d        = '0;
            state_d       = ST_IDLE;
          end
        end else begin
          cnt_d    = CW'(first_q);
          listed_d = '0;
          state_d  = ST_LIST_RD;
        end
      end

      ST_LIST_RD: begin
        st_ctrl.rd_en = 1'b1;
        state_d       = ST_LIST_EV;
      end

      ST_LIST_EV: begin
        if (st_rd_len == best_q) begin
          if (out_free) begin
            out_load   = 1'b1;
            out_last_d = (listed_q + 1'b1) == total;
            if (out_last_d) begin
              st_ctrl.clear = 1'b1;
              qpos_d        = '0;
              state_d       = ST_IDLE;
            end else begin
              listed_d = listed_q + 1'b1;
              cnt_d    = cnt_q + 1'b1;
              state_d  = ST_LIST_RD;
            end
          end
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = ST_LIST_RD;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      pv_q          <= 1'b0;
      qpos_q        <= '0;
      entry_count_q <= '0;
      m_tvalid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pv_q    <= pv_d;
      qpos_q  <= qpos_d;
      if (cfg_we) begin
        entry_count_q <= pwdata[CNT_REG_W-1:0];
      end
      if (out_load) begin
        m_tvalid_q <= 1'b1;
      end else if (m_tready) begin
        m_tvalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pidx_q        <= pidx_d;
    char_q        <= char_d;
    best_q        <= best_d;
    first_q       <= first_d;
    ties_q        <= ties_d;
    first_still_q <= first_still_d;
    listed_q      <= listed_d;
    empty_q       <= empty_d;
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_idx_q  <= out_idx_d;
      out_str_q  <= out_str_d;
      out_ties_q <= out_ties_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      name_mem[tbl_wr_addr] <= in_char;
    end
    if (tbl_rd_en) begin
      tbl_char_q <= name_mem[tbl_rd_addr];
    end
  end

  cpm_state_mem #(
    .NUM_ENTRIES (NUM_ENTRIES),
    .NAME_LEN    (NAME_LEN)
  ) u_state_mem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (st_ctrl),
    .rd_addr_i  (st_rd_addr),
    .wr_addr_i  (pidx_q),
    .wr_len_i   (st_wr_len),
    .rd_still_o (st_rd_still),
    .rd_len_o   (st_rd_len)
  );

  assign m_tvalid = m_tvalid_q;
  assign m_tdata  = {3'b000, out_ties_q, out_str_q, out_idx_q};
  assign m_tuser  = out_kind_q;
  assign m_tlast  = out_last_q;

endmodule

>>> hw/rtl/cpm_checker.sv
// Port-level checks for the command prefix matcher core, bound into every instance of the core.
// Depends on cpm_pkg for field widths and result kinds.
module cpm_checker
  import cpm_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic [IN_TDATA_W-1:0]  s_tdata,
  input logic [0:0]             s_tuser,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [1:0]             m_tuser,
  input logic                   m_tlast
);

  // A stalled result item holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("result item changed while stalled");

  // An exact match and an empty table each give exactly one result.
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && (m_tuser == KIND_EXACT || m_tuser == KIND_EMPTY) |-> m_tlast)
    else $error("single result without last");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid && m_tuser == KIND_EMPTY |-> m_tdata == '0)
    else $error("empty table result carries data");

  // After a name character the input is ready again in the next cycle.
  a_load_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready && s_tuser[0] == MODE_LOAD |=> s_tready)
    else $error("not ready after a name character");

  // A query character walks the table, so the next item must wait.
  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid && s_tready && s_tuser[0] == MODE_QUERY && s_tdata[15:8] != '0 |=> !s_tready)
    else $error("ready during a table walk");

endmodule

bind command_prefix_matcher_core cpm_checker u_cpm_checker (.*);

>>> bench/tb_command_prefix_matcher_core.sv
// Testbench for command_prefix_matcher_core: loads name tables, streams query words
// and checks every result item against a built-in predictor of the prefix match.
// Depends on cpm_pkg and the RTL of the core and its entry state memory.
module tb_command_prefix_matcher_core;
  import cpm_pkg::*;

  localparam int unsigned NUM_ENT        = NUM_ENTRIES_DEF;
  localparam int unsigned SLOTS          = NAME_LEN_DEF;
  localparam int unsigned RANDOM_ITEMS   = 280;
  localparam int unsigned PHASE_ITEMS    = 55;
  localparam int unsigned SETTLE_CYCLES  = 2 * NUM_ENT + 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    mode_e             mode;
    logic [IDX_W-1:0]  ent;
    logic [3:0]        pos;
    logic [CHAR_W-1:0] ch;
  } char_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [IDX_W-1:0]  idx;
    logic [STR_W-1:0]  strength;
    logic [TIE_W-1:0]  ties;
    logic              last;
  } match_result_t;

  logic                   clk_i;
  logic                   rst_ni   = 1'b0;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [PADDR_W-1:0]     paddr    = '0;
  logic [PDATA_W-1:0]     pwdata   = '0;
  logic [PDATA_W-1:0]     prdata;
  logic                   pready;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;  // entry[3:0], position[7:4], char_code[15:8]
  logic [0:0]             s_tuser  = '0;  // mode[0]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // entry_index[3:0], strength[7:4], tie_count[12:8]
  logic [1:0]             m_tuser;        // kind[1:0]
  logic                   m_tlast;

  command_prefix_matcher_core i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // Predictor state, advanced as items are accepted.
  logic [7:0]    pred_name [NUM_ENT][SLOTS];
  bit            pred_live [NUM_ENT];
  int            pred_len  [NUM_ENT];
  int            pred_qpos;
  int            pred_count;
  match_result_t awaited_results [$];

  // Table contents as the stimulus will have left them, used to build queries.
  logic [7:0]    plan_name [NUM_ENT][SLOTS];
  bit            plan_set  [NUM_ENT][SLOTS];
  char_item_t    pending_items [$];
  char_item_t    next_item;

  bit steady_flow = 1'b1;
  int gap_left, hold_left, quiet_cycles;
  int n_queued, n_accepted, n_results, n_mismatch, n_settings;
  int n_exact, n_suggest, n_empty;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady_flow) return 0;
    r = $urandom_range(99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // The last slot of a name and anything past it always read as a terminator.
  function automatic logic [7:0] stored_char(int e, int p);
    if (p + 1 >= SLOTS) return 8'h00;
    return pred_name[e][p];
  endfunction

  task automatic clear_walk();
    int i;
    for (i = 0; i < NUM_ENT; i++) begin
      pred_live[i] = 1'b1;
      pred_len[i]  = 0;
    end
    pred_qpos = 0;
  endtask

  task automatic push_result(input kind_e kind, input logic [IDX_W-1:0] idx,
                             input logic [STR_W-1:0] strength,
                             input logic [TIE_W-1:0] ties, input logic last);
    match_result_t r;
    r.kind     = kind;
    r.idx      = idx;
    r.strength = strength;
    r.ties     = ties;
    r.last     = last;
    awaited_results.push_back(r);
  endtask

  task automatic walk_name_table(input mode_e mode, input logic [3:0] ent,
                                 input logic [3:0] pos, input logic [7:0] ch);
    int i, n, best, first, ties, total, k;
    if (mode == MODE_LOAD) begin
      pred_name[ent][pos] = ch;
    end else if (ch != 8'h00) begin
      for (i = 0; i < NUM_ENT; i++) begin
        if (pred_live[i] && stored_char(i, pred_qpos) == ch) pred_len[i]++;
        else pred_live[i] = 1'b0;
      end
      if (pred_qpos < 31) pred_qpos++;
    end else begin
      n = (pred_count < NUM_ENT) ? pred_count : NUM_ENT;
      if (n == 0) begin
        push_result(KIND_EMPTY, '0, '0, '0, 1'b1);
      end else begin
        best  = 0;
        first = 0;
        ties  = 0;
        // Ties are counted at strength zero as well.
        for (i = 0; i < n; i++) begin
          if (pred_len[i] > best) begin
            best  = pred_len[i];
            first = i;
            ties  = 1;
          end else if (pred_len[i] == best) begin
            ties++;
          end
        end
        if (ties == 1 && pred_live[first] && stored_char(first, pred_qpos) == 8'h00) begin
          push_result(KIND_EXACT, IDX_W'(first), STR_W'(best), TIE_W'(ties), 1'b1);
        end else begin
          total = 0;
          for (i = first; i < n; i++)
            if (pred_len[i] == best && total < MAX_RESULTS) total++;
          k = 0;
          for (i = first; i < n && k < total; i++) begin
            if (pred_len[i] == best) begin
              push_result(KIND_SUGGEST, IDX_W'(i), STR_W'(best), TIE_W'(ties),
                          k == total - 1);
              k++;
            end
          end
        end
      end
      clear_walk();
    end
  endtask

  task automatic check_result();
    match_result_t got, want;
    got.kind     = kind_e'(m_tuser);
    got.idx      = m_tdata[IDX_W-1:0];
    got.strength = m_tdata[IDX_W+STR_W-1:IDX_W];
    got.ties     = m_tdata[IDX_W+STR_W+TIE_W-1:IDX_W+STR_W];
    got.last     = m_tlast;
    n_results++;
    case (got.kind)
      KIND_EXACT:   n_exact++;
      KIND_SUGGEST: n_suggest++;
      default:      n_empty++;
    endcase
    if (awaited_results.size() == 0) begin
      if (n_mismatch < 10)
        $display("unexpected result item: kind %0d entry %0d strength %0d ties %0d last %0d",
                 got.kind, got.idx, got.strength, got.ties, got.last);
      n_mismatch++;
    end else begin
      want = awaited_results.pop_front();
      if (got !== want) begin
        if (n_mismatch < 10)
          $display("result %0d: expected kind %0d entry %0d strength %0d ties %0d last %0d, %s",
                   n_results, want.kind, want.idx, want.strength, want.ties, want.last,
                   $sformatf("got kind %0d entry %0d strength %0d ties %0d last %0d",
                             got.kind, got.idx, got.strength, got.ties, got.last));
        n_mismatch++;
      end
    end
  endtask

  // Driver: one item at a time from the pending queue, with a random gap after each.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        walk_name_table(mode_e'(s_tuser[0]), s_tdata[3:0], s_tdata[7:4], s_tdata[15:8]);
        n_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          s_tvalid  <= 1'b1;
          s_tdata   <= {next_item.ch, next_item.pos, next_item.ent};
          s_tuser   <= next_item.mode;
          gap_left  <= idle_len();
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: takes result items and stalls the result side at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_tready  <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(99) < 20) hold_left <= idle_len();
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("no progress for %0d cycles", WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic queue_item(input mode_e mode, input int e, input int p, input int c);
    char_item_t it;
    it.mode = mode;
    it.ent  = IDX_W'(e);
    it.pos  = 4'(p);
    it.ch   = CHAR_W'(c);
    pending_items.push_back(it);
    n_queued++;
  endtask

  // A nonzero character is only written where the slot after it already holds
  // something, so a query never walks into a slot that was never loaded.
  task automatic load_char(input int e, input int p, input int c);
    if (c != 0 && p < SLOTS - 2 && !plan_set[e][p+1]) begin
      queue_item(MODE_LOAD, e, p + 1, 0);
      plan_name[e][p+1] = 8'h00;
      plan_set[e][p+1]  = 1'b1;
    end
    queue_item(MODE_LOAD, e, p, c);
    plan_name[e][p] = 8'(c);
    plan_set[e][p]  = 1'b1;
  endtask

  // A small alphabet most of the time, so that names share prefixes and tie.
  function automatic int pick_char();
    if ($urandom_range(99) < 70) return 8'h61 + $urandom_range(3);
    return $urandom_range(255, 1);
  endfunction

  task automatic load_name(input int e, input int len);
    int i;
    if (len < SLOTS - 1) load_char(e, len, 0);
    for (i = len - 1; i >= 0; i--) load_char(e, i, pick_char());
  endtask

  function automatic int plan_len(int e);
    int i;
    i = 0;
    while (i < SLOTS - 1 && plan_name[e][i] != 8'h00) i++;
    return i;
  endfunction

  // Query characters carry random entry and position bits, which the block ignores;
  // now and then a table write slips in between them.
  task automatic query_char(input int c);
    if ($urandom_range(99) < 6)
      load_char($urandom_range(NUM_ENT - 1), $urandom_range(SLOTS - 1), $urandom_range(255));
    queue_item(MODE_QUERY, $urandom_range(15), $urandom_range(15), c);
  endtask

  task automatic end_query();
    queue_item(MODE_QUERY, $urandom_range(15), $urandom_range(15), 0);
  endtask

  task automatic name_query(input int e);
    logic [7:0] word [SLOTS];
    int len, k, r, i;
    len = plan_len(e);
    for (i = 0; i < SLOTS; i++) word[i] = plan_name[e][i];
    r = $urandom_range(99);
    k = (r < 50) ? len : $urandom_range(len);
    for (i = 0; i < k; i++) query_char(word[i]);
    if (r >= 50 && r < 75)
      for (i = $urandom_range(2, 1); i > 0; i--) query_char(pick_char());
    end_query();
  endtask

  task automatic noise_query(input int len);
    int i;
    for (i = 0; i < len; i++) query_char(pick_char());
    end_query();
  endtask

  task automatic random_burst(input int budget);
    int start, r;
    start = n_queued;
    while (n_queued - start < budget) begin
      r = $urandom_range(99);
      if (r < 55)
        name_query($urandom_range(NUM_ENT - 1));
      else if (r < 65)
        load_name($urandom_range(NUM_ENT - 1),
                  ($urandom_range(99) < 70) ? $urandom_range(4, 1) : $urandom_range(SLOTS - 1));
      else if (r < 75)
        load_char($urandom_range(NUM_ENT - 1), $urandom_range(SLOTS - 1), $urandom_range(255));
      else if (r < 90)
        noise_query($urandom_range(5));
      else if (r < 93)
        noise_query($urandom_range(36, 32));
      else
        end_query();
    end
  endtask

  task automatic set_entry_count(input int v);
    logic [PDATA_W-1:0] back;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_ENTRY_COUNT, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel       <= 1'b0;
    penable    <= 1'b0;
    pred_count = v;
    @(posedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    back = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (back !== v) begin
      if (n_mismatch < 10) $display("entry count read back: expected %0d, got %0d", v, back);
      n_mismatch++;
    end
    n_settings++;
  endtask

  task automatic drain();
    while (n_accepted != n_queued || awaited_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    int i, phase, random_start, count;
    clear_walk();
    pred_count = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // The register resets to zero, so a bare terminator finds an empty table.
    end_query();
    drain();
    steady_flow = 1'b0;
    set_entry_count(NUM_ENT);

    load_name(0, 0);
    for (i = 1; i < 13; i++) load_name(i, $urandom_range(4, 1));
    load_name(13, 3);
    load_char(14, 3, 0);
    for (i = 2; i >= 0; i--) load_char(14, i, plan_name[13][i]);
    for (i = SLOTS - 2; i >= 0; i--)
      load_char(15, i, (i == 0) ? 8'hFF : (i == 1) ? 8'h01 : 8'h80 | i);
    // The final slot is written but must still read as a terminator.
    load_char(15, SLOTS - 1, 8'hAA);

    for (i = 0; i < SLOTS - 1; i++) queue_item(MODE_QUERY, 15, 15, plan_name[15][i]);
    end_query();
    queue_item(MODE_QUERY, 0, 0, 0);
    for (i = 0; i < 3; i++) queue_item(MODE_QUERY, 0, 0, plan_name[13][i]);
    end_query();
    queue_item(MODE_QUERY, 15, 15, 8'hFF);
    end_query();
    drain();

    set_entry_count(0);
    queue_item(MODE_QUERY, 5, 10, 8'h61);
    end_query();
    drain();
    set_entry_count(31);
    end_query();
    drain();
    set_entry_count(1);
    end_query();
    drain();

    random_start = n_queued;
    phase = 0;
    while (n_queued - random_start < RANDOM_ITEMS) begin
      case (phase)
        0: count = NUM_ENT;
        1: count = 1;
        2: count = 0;
        3: count = 31;
        default: count = ($urandom_range(99) < 80) ? $urandom_range(NUM_ENT, 2)
                                                   : $urandom_range(31, NUM_ENT + 1);
      endcase
      set_entry_count(count);
      steady_flow = ($urandom_range(3) == 0);
      random_burst(PHASE_ITEMS);
      drain();
      phase++;
    end

    n_mismatch += awaited_results.size();
    $display("%0d items sent under %0d entry count settings, %0d result items checked",
             n_queued, n_settings, n_results);
    $display("(%0d exact, %0d suggestion, %0d empty table), %0d mismatches",
             n_exact, n_suggest, n_empty, n_mismatch);
    if (n_mismatch == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
